/* sv/pau_pkg.sv */
// Shared constants, types and helpers for the particle attractor update pipeline.
package pau_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int FRAC_BITS   = 12;
   localparam int CFG_WIDTH   = 12;
   localparam int NUM_ATTR    = 2;

   localparam int DW   = COORD_WIDTH + 1;
   localparam int SQW  = 2 * DW;
   localparam int R2W  = SQW + 1 - FRAC_BITS;
   localparam int SUMW = COORD_WIDTH + 2;

   localparam longint unsigned G_FIX   = ((64'd6674 << FRAC_BITS) + 64'd500) / 64'd1000;
   localparam longint unsigned NUM     = G_FIX << FRAC_BITS;
   localparam int              NUM_W   = $clog2(NUM + 1);
   localparam int              DEN_W   = NUM_W + 1;
   localparam longint unsigned NEAR_R2 = 64'd225 << FRAC_BITS;
   localparam longint unsigned MIN_DEN = NEAR_R2 / 64'd100;
   localparam int              QW      = $clog2(NUM / MIN_DEN + 1);
   localparam longint unsigned DEN_CAP = 64'd1 << NUM_W;

   localparam int              Y_W     = 32;
   localparam int              SAT_W   = Y_W + 2;
   localparam int              RECIP_K = Y_W + 5;
   localparam int              M_W     = 33;
   localparam longint unsigned RECIP_M = ((64'd1 << RECIP_K) + 64'd24) / 64'd25;

   typedef enum logic [2:0] {
      CSR_A_X    = 3'd0,
      CSR_A_Y    = 3'd1,
      CSR_B_X    = 3'd2,
      CSR_B_Y    = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic signed [COORD_WIDTH-1:0] vx;
      logic signed [COORD_WIDTH-1:0] vy;
      logic [NUM_ATTR-1:0]           neg_x;
      logic [NUM_ATTR-1:0]           neg_y;
      logic [NUM_ATTR-1:0]           skip;
   } item_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [SUMW-1:0] x);
      logic signed [SUMW-1:0] hi;
      logic signed [SUMW-1:0] lo;
      begin
         hi = SUMW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
         lo = -hi - SUMW'(1);
         if (x > hi) sat_coord = hi[COORD_WIDTH-1:0];
         else if (x < lo) sat_coord = lo[COORD_WIDTH-1:0];
         else sat_coord = x[COORD_WIDTH-1:0];
      end
   endfunction

   function automatic logic signed [SUMW-1:0] add_pull(
      input logic signed [COORD_WIDTH-1:0] v, input logic [QW-1:0] a, input logic neg);
      logic signed [SUMW-1:0] ve;
      logic signed [SUMW-1:0] ae;
      begin
         ve = SUMW'(v);
         ae = signed'({{(SUMW-QW){1'b0}}, a});
         add_pull = neg ? ve - ae : ve + ae;
      end
   endfunction

endpackage

/* sv/particle_attractor_update.sv */
// Particle attractor update: pipeline, one particle in and out per cycle unless stalled.
//
// A particle (position and velocity, signed Q12.12) arrives on the req_ channel and its
// next state leaves on the rsp_ channel. A beat is taken at a clock edge where valid is
// high and stall is low. Each of two attractors adds 6.674/r2 (667.4/r2 past the far
// limit) to velocity; the particle moves, or stops at the frame edge, velocity zeroed.
// The csr_ port writes the attractor positions and frame size; write it only while no
// particle is in flight.
// A new particle may enter every cycle while req_stall is low. The depth is set by the
// 14-stage restoring divider that forms the pull, one quotient bit per stage, both
// attractors side by side.
// When rsp_stall is high and a result is held, the whole pipeline freezes and req_stall
// rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipeline and restores the registers: attractors at the
// origin and an 800 by 800 frame.
module particle_attractor_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [2:0]                            csr_index,
   input  logic [pau_pkg::CFG_WIDTH-1:0]         csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pau_pkg::COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [pau_pkg::COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [pau_pkg::COORD_WIDTH-1:0] req_vel_x,
   input  logic signed [pau_pkg::COORD_WIDTH-1:0] req_vel_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pau_pkg::COORD_WIDTH-1:0] rsp_new_pos_x,
   output logic signed [pau_pkg::COORD_WIDTH-1:0] rsp_new_pos_y,
   output logic signed [pau_pkg::COORD_WIDTH-1:0] rsp_new_vel_x,
   output logic signed [pau_pkg::COORD_WIDTH-1:0] rsp_new_vel_y,
   output logic                                  rsp_stopped_at_edge
);
   import pau_pkg::*;

   logic signed [CFG_WIDTH-1:0] attr_x_ff [NUM_ATTR];
   logic signed [CFG_WIDTH-1:0] attr_y_ff [NUM_ATTR];
   logic [CFG_WIDTH-1:0]        width_ff;
   logic [CFG_WIDTH-1:0]        height_ff;

   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ATTR; k++) begin
            attr_x_ff[k] <= '0;
            attr_y_ff[k] <= '0;
         end
         width_ff  <= CFG_WIDTH'(800);
         height_ff <= CFG_WIDTH'(800);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_A_X:    attr_x_ff[0] <= csr_wdata;
            CSR_A_Y:    attr_y_ff[0] <= csr_wdata;
            CSR_B_X:    attr_x_ff[1] <= csr_wdata;
            CSR_B_Y:    attr_y_ff[1] <= csr_wdata;
            CSR_WIDTH:  width_ff     <= csr_wdata;
            CSR_HEIGHT: height_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: offsets to each attractor, their magnitudes and signs.
   item_type          it1_in;
   logic [DW-1:0]     mx1_in [NUM_ATTR];
   logic [DW-1:0]     my1_in [NUM_ATTR];
   logic              v1_ff;
   item_type          it1_ff;
   logic [DW-1:0]     mx1_ff [NUM_ATTR];
   logic [DW-1:0]     my1_ff [NUM_ATTR];

   always_comb begin
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [DW-1:0] neg_one;
      neg_one = -DW'(64'd1 << FRAC_BITS);
      it1_in.px = req_pos_x;
      it1_in.py = req_pos_y;
      it1_in.vx = req_vel_x;
      it1_in.vy = req_vel_y;
      for (int k = 0; k < NUM_ATTR; k++) begin
         dx = signed'({{(DW-CFG_WIDTH-FRAC_BITS){attr_x_ff[k][CFG_WIDTH-1]}}, attr_x_ff[k],
                       {FRAC_BITS{1'b0}}}) - DW'(req_pos_x);
         dy = signed'({{(DW-CFG_WIDTH-FRAC_BITS){attr_y_ff[k][CFG_WIDTH-1]}}, attr_y_ff[k],
                       {FRAC_BITS{1'b0}}}) - DW'(req_pos_y);
         it1_in.neg_x[k] = dx <= neg_one;
         it1_in.neg_y[k] = dy <= neg_one;
         it1_in.skip[k]  = (dx == '0) && (dy == '0);
         mx1_in[k] = dx[DW-1] ? unsigned'(-dx) : unsigned'(dx);
         my1_in[k] = dy[DW-1] ? unsigned'(-dy) : unsigned'(dy);
      end
   end

   // Stage 2: squares.
   logic              v2_ff;
   item_type          it2_ff;
   logic [SQW-1:0]    sqx2_ff [NUM_ATTR];
   logic [SQW-1:0]    sqy2_ff [NUM_ATTR];

   // Stage 3: r2 with the near clamp and the far test.
   logic              v3_ff;
   item_type          it3_ff;
   logic [R2W-1:0]    r2_3_ff [NUM_ATTR];
   logic              far3_ff [NUM_ATTR];
   logic [R2W-1:0]    r2_3_in [NUM_ATTR];
   logic              far3_in [NUM_ATTR];

   always_comb begin
      logic [SQW:0]           sum;
      logic [R2W-1:0]         r2;
      logic [CFG_WIDTH:0]     wh;
      logic [2*CFG_WIDTH-1:0] far2;
      logic [R2W-1:0]         far_lim;
      wh      = {1'b0, width_ff} + {1'b0, height_ff};
      far2    = wh[CFG_WIDTH:1] * wh[CFG_WIDTH:1];
      far_lim = R2W'(far2) << FRAC_BITS;
      for (int k = 0; k < NUM_ATTR; k++) begin
         sum = {1'b0, sqx2_ff[k]} + {1'b0, sqy2_ff[k]};
         r2  = sum[SQW:FRAC_BITS];
         if (r2 < R2W'(NEAR_R2)) r2 = R2W'(NEAR_R2);
         r2_3_in[k] = r2;
         far3_in[k] = r2 > far_lim;
      end
   end

   // Stage 4: r2 / 100 by reciprocal multiply, and r2 capped for the divider.
   logic              v4_ff;
   item_type          it4_ff;
   logic [DEN_W-1:0]  q100_4_ff [NUM_ATTR];
   logic [DEN_W-1:0]  r2c_4_ff [NUM_ATTR];
   logic              far4_ff [NUM_ATTR];
   logic [DEN_W-1:0]  q100_4_in [NUM_ATTR];
   logic [DEN_W-1:0]  r2c_4_in [NUM_ATTR];

   always_comb begin
      logic [SAT_W-1:0]   rs;
      logic [Y_W+M_W-1:0] prod;
      for (int k = 0; k < NUM_ATTR; k++) begin
         rs = (r2_3_ff[k] > R2W'({SAT_W{1'b1}})) ? {SAT_W{1'b1}} : r2_3_ff[k][SAT_W-1:0];
         prod = rs[SAT_W-1:2] * M_W'(RECIP_M);
         q100_4_in[k] = prod[RECIP_K +: DEN_W];
         r2c_4_in[k]  = (r2_3_ff[k] > R2W'(DEN_CAP)) ? DEN_W'(DEN_CAP) : r2_3_ff[k][DEN_W-1:0];
      end
   end

   // Divider: stage 0 holds the chosen divisor, each further stage one quotient bit.
   logic              dv_ff  [QW+1];
   item_type          dit_ff [QW+1];
   logic [DEN_W-1:0]  den_ff [NUM_ATTR][QW+1];
   logic [DEN_W-1:0]  rem_ff [NUM_ATTR][QW+1];
   logic [QW-1:0]     quo_ff [NUM_ATTR][QW+1];

   // Velocity stages and output.
   logic              v6_ff;
   item_type          it6_ff;
   logic [QW-1:0]     ab6_ff;
   logic              v7_ff;
   item_type          it7_ff;
   logic              vo_ff;
   logic signed [COORD_WIDTH-1:0] opx_ff, opy_ff, ovx_ff, ovy_ff;
   logic              ostop_ff;

   assign adv       = !vo_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int j = 0; j <= QW; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         dv_ff[0] <= v4_ff;
         for (int j = 0; j < QW; j++) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         v6_ff <= dv_ff[QW];
         v7_ff <= v6_ff;
         vo_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [DEN_W:0] trial;
      if (adv) begin
         it1_ff <= it1_in;
         it2_ff <= it1_ff;
         it3_ff <= it2_ff;
         it4_ff <= it3_ff;
         dit_ff[0] <= it4_ff;
         for (int k = 0; k < NUM_ATTR; k++) begin
            mx1_ff[k]    <= mx1_in[k];
            my1_ff[k]    <= my1_in[k];
            sqx2_ff[k]   <= mx1_ff[k] * mx1_ff[k];
            sqy2_ff[k]   <= my1_ff[k] * my1_ff[k];
            r2_3_ff[k]   <= r2_3_in[k];
            far3_ff[k]   <= far3_in[k];
            q100_4_ff[k] <= q100_4_in[k];
            r2c_4_ff[k]  <= r2c_4_in[k];
            far4_ff[k]   <= far3_ff[k];
            den_ff[k][0] <= !far4_ff[k] ? r2c_4_ff[k] :
                            (q100_4_ff[k] > DEN_W'(DEN_CAP)) ? DEN_W'(DEN_CAP) : q100_4_ff[k];
            rem_ff[k][0] <= DEN_W'(NUM >> QW);
            quo_ff[k][0] <= '0;
         end
         for (int j = 0; j < QW; j++) begin
            dit_ff[j+1] <= dit_ff[j];
            for (int k = 0; k < NUM_ATTR; k++) begin
               trial = {rem_ff[k][j], NUM[QW-1-j]};
               den_ff[k][j+1] <= den_ff[k][j];
               if (trial >= {1'b0, den_ff[k][j]}) begin
                  rem_ff[k][j+1] <= DEN_W'(trial - {1'b0, den_ff[k][j]});
                  quo_ff[k][j+1] <= {quo_ff[k][j][QW-2:0], 1'b1};
               end else begin
                  rem_ff[k][j+1] <= trial[DEN_W-1:0];
                  quo_ff[k][j+1] <= {quo_ff[k][j][QW-2:0], 1'b0};
               end
            end
         end
      end
   end

   item_type it6_in;
   item_type it7_in;
   logic [QW-1:0] aa;
   logic signed [SUMW-1:0] nx, ny, hx, hy;
   logic in_frame;

   always_comb begin
      it6_in = dit_ff[QW];
      aa = dit_ff[QW].skip[0] ? '0 : quo_ff[0][QW];
      it6_in.vx = sat_coord(add_pull(dit_ff[QW].vx, aa, dit_ff[QW].neg_x[0]));
      it6_in.vy = sat_coord(add_pull(dit_ff[QW].vy, aa, dit_ff[QW].neg_y[0]));
      it7_in = it6_ff;
      it7_in.vx = sat_coord(add_pull(it6_ff.vx, ab6_ff, it6_ff.neg_x[1]));
      it7_in.vy = sat_coord(add_pull(it6_ff.vy, ab6_ff, it6_ff.neg_y[1]));
      nx = SUMW'(it7_ff.px) + SUMW'(it7_ff.vx);
      ny = SUMW'(it7_ff.py) + SUMW'(it7_ff.vy);
      hx = signed'({{(SUMW-CFG_WIDTH+1-FRAC_BITS){1'b0}}, width_ff[CFG_WIDTH-1:1],
                    {FRAC_BITS{1'b0}}});
      hy = signed'({{(SUMW-CFG_WIDTH+1-FRAC_BITS){1'b0}}, height_ff[CFG_WIDTH-1:1],
                    {FRAC_BITS{1'b0}}});
      in_frame = (nx < hx) && (nx > -hx) && (ny < hy) && (ny > -hy);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it6_ff <= it6_in;
         ab6_ff <= dit_ff[QW].skip[1] ? '0 : quo_ff[1][QW];
         it7_ff <= it7_in;
         if (in_frame) begin
            opx_ff <= sat_coord(nx);
            opy_ff <= sat_coord(ny);
            ovx_ff <= it7_ff.vx;
            ovy_ff <= it7_ff.vy;
         end else begin
            opx_ff <= it7_ff.px;
            opy_ff <= it7_ff.py;
            ovx_ff <= '0;
            ovy_ff <= '0;
         end
         ostop_ff <= !in_frame;
      end
   end

   assign rsp_valid           = vo_ff;
   assign rsp_new_pos_x       = opx_ff;
   assign rsp_new_pos_y       = opy_ff;
   assign rsp_new_vel_x       = ovx_ff;
   assign rsp_new_vel_y       = ovy_ff;
   assign rsp_stopped_at_edge = ostop_ff;

endmodule
